/* design/ssu_pkg.sv */
// Shared types and constants for the sorted set union merge block.
// No dependencies; used by every module of the block except ssu_ram.
`timescale 1ns / 1ps

package ssu_pkg;

  localparam int VALUE_W    = 32;
  localparam int FUNC_W     = 2;
  localparam int POS_W      = 6;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 40;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD_A = 2'd0,
    FUNC_LOAD_B = 2'd1,
    FUNC_MERGE  = 2'd2
  } func_t;

  // controller to datapath
  typedef struct packed {
    logic load_a;
    logic load_b;
    logic start;
    logic step;
  } ssu_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
    logic last_step;
  } ssu_sts_t;

endpackage

/* design/ssu_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ssu_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 32,
  parameter int ADDR_W = 5
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* design/ssu_ctrl.sv */
// Controller for the sorted set union merge: decodes input beats and runs
// the merge walk. Depends on ssu_pkg.
`timescale 1ns / 1ps

module ssu_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  input  logic [ssu_pkg::FUNC_W-1:0]   func,
  output logic                         in_tready,
  input  ssu_pkg::ssu_sts_t            sts,
  output ssu_pkg::ssu_cmd_t            cmd
);

  import ssu_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_MERGE
  } state_t;

  state_t state_r, state_nxt;
  logic   in_fire;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (func_t'(func))
            FUNC_LOAD_A: cmd.load_a = 1'b1;
            FUNC_LOAD_B: cmd.load_b = 1'b1;
            FUNC_MERGE: begin
              cmd.start = 1'b1;
              state_nxt = ST_MERGE;
            end
            default: ;
          endcase
        end
      end
      ST_MERGE: begin
        // one union element per cycle while the output register has room
        cmd.step = sts.out_free;
        if (sts.last_step) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* design/ssu_dpath.sv */
// Datapath for the sorted set union merge: list memories, counts, walk
// indexes, head compare and output register. Depends on ssu_pkg, ssu_ram.
`timescale 1ns / 1ps

module ssu_dpath #(
  parameter int LIST_DEPTH = 32,
  parameter int CNT_W      = 6,
  parameter int ADDR_W     = 5
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [ssu_pkg::VALUE_W-1:0]   value,
  input  ssu_pkg::ssu_cmd_t             cmd,
  output ssu_pkg::ssu_sts_t             sts,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [ssu_pkg::VALUE_W-1:0]   value_res,
  output logic [ssu_pkg::POS_W-1:0]     position,
  output logic                          last,
  output logic                          is_empty
);

  import ssu_pkg::*;

  logic [CNT_W-1:0]   count_a_r, count_b_r;
  logic [CNT_W-1:0]   na_r, nb_r;
  logic [CNT_W-1:0]   i_r, i_nxt, j_r, j_nxt;
  logic [POS_W-1:0]   pos_r;
  logic [VALUE_W-1:0] rd_a, rd_b;
  logic               wr_a, wr_b;
  logic               a_left, b_left, take_a, take_b, empty_u, last_u;
  logic [VALUE_W-1:0] head_v;

  logic               out_valid_r;
  logic [VALUE_W-1:0] out_value_r;
  logic [POS_W-1:0]   out_pos_r;
  logic               out_last_r, out_empty_r;

  assign wr_a = cmd.load_a && (count_a_r < CNT_W'(LIST_DEPTH));
  assign wr_b = cmd.load_b && (count_b_r < CNT_W'(LIST_DEPTH));

  // read address follows the next index so the head is ready each cycle
  ssu_ram #(.WIDTH(VALUE_W), .DEPTH(LIST_DEPTH), .ADDR_W(ADDR_W)) u_ram_a (
    .clk     (clk),
    .wr_en   (wr_a),
    .wr_addr (count_a_r[ADDR_W-1:0]),
    .wr_data (value),
    .rd_addr (i_nxt[ADDR_W-1:0]),
    .rd_data (rd_a)
  );

  ssu_ram #(.WIDTH(VALUE_W), .DEPTH(LIST_DEPTH), .ADDR_W(ADDR_W)) u_ram_b (
    .clk     (clk),
    .wr_en   (wr_b),
    .wr_addr (count_b_r[ADDR_W-1:0]),
    .wr_data (value),
    .rd_addr (j_nxt[ADDR_W-1:0]),
    .rd_data (rd_b)
  );

  assign a_left  = (i_r < na_r);
  assign b_left  = (j_r < nb_r);
  assign empty_u = !a_left && !b_left;
  // equal heads take both
  assign take_a  = a_left && (!b_left || ($signed(rd_a) <= $signed(rd_b)));
  assign take_b  = b_left && (!a_left || ($signed(rd_b) <= $signed(rd_a)));
  assign head_v  = empty_u ? '0 : (take_a ? rd_a : rd_b);

  always_comb begin
    i_nxt  = i_r;
    j_nxt  = j_r;
    last_u = 1'b0;
    if (cmd.step) begin
      last_u = empty_u ||
               (((i_r + CNT_W'(take_a)) == na_r) && ((j_r + CNT_W'(take_b)) == nb_r));
      if (last_u) begin
        i_nxt = '0;
        j_nxt = '0;
      end else begin
        i_nxt = i_r + CNT_W'(take_a);
        j_nxt = j_r + CNT_W'(take_b);
      end
    end
  end

  assign sts.out_free  = !out_valid_r || out_tready;
  assign sts.last_step = cmd.step && last_u;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_a_r   <= '0;
      count_b_r   <= '0;
      na_r        <= '0;
      nb_r        <= '0;
      i_r         <= '0;
      j_r         <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      i_r <= i_nxt;
      j_r <= j_nxt;
      if (cmd.start) begin
        na_r      <= count_a_r;
        nb_r      <= count_b_r;
        count_a_r <= '0;
        count_b_r <= '0;
        pos_r     <= '0;
      end else begin
        if (wr_a) count_a_r <= count_a_r + CNT_W'(1);
        if (wr_b) count_b_r <= count_b_r + CNT_W'(1);
      end
      if (cmd.step) begin
        pos_r       <= pos_r + POS_W'(1);
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      out_value_r <= head_v;
      out_pos_r   <= pos_r;
      out_last_r  <= last_u;
      out_empty_r <= empty_u;
    end
  end

  assign out_tvalid = out_valid_r;
  assign value_res  = out_value_r;
  assign position   = out_pos_r;
  assign last       = out_last_r;
  assign is_empty   = out_empty_r;

endmodule

/* design/sorted_set_union_merge.sv */
// Top level of the sorted set union merge: stream ports, controller and
// datapath. Depends on ssu_pkg, ssu_ctrl, ssu_dpath (and ssu_ram below it).
//
//  channel | dir | tdata                              | tuser      | tlast
//  --------+-----+------------------------------------+------------+-----------
//  in_     | in  | [31:0] value                       | [1:0] func | -
//  out_    | out | [31:0] value_res, [37:32] position | [0] empty  | last
//
// load beats can be taken back to back; a merge beat starts a walk that emits
// one union element per step (a single empty element for an empty union); the
// walk reads one head per list ram per cycle
// results leave through an output register, so a stalled out_ side only
// holds the walk; reset clears the counts, list contents need no clearing
// input beats are refused while a merge walk is running
`timescale 1ns / 1ps

module sorted_set_union_merge #(
  parameter int LIST_DEPTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [ssu_pkg::IN_DATA_W-1:0]     in_tdata,   // [31:0] value
  input  logic [ssu_pkg::FUNC_W-1:0]        in_tuser,   // [1:0] func
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [ssu_pkg::OUT_DATA_W-1:0]    out_tdata,  // [31:0] value_res, [37:32] position
  output logic [0:0]                        out_tuser,  // [0] is_empty
  output logic                              out_tlast
);

  import ssu_pkg::*;

  localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
  localparam int ADDR_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

  ssu_cmd_t           cmd;
  ssu_sts_t           sts;
  logic [VALUE_W-1:0] value_res;
  logic [POS_W-1:0]   position;
  logic               is_empty;

  ssu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .func      (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ssu_dpath #(
    .LIST_DEPTH (LIST_DEPTH),
    .CNT_W      (CNT_W),
    .ADDR_W     (ADDR_W)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .value      (in_tdata[VALUE_W-1:0]),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .value_res  (value_res),
    .position   (position),
    .last       (out_tlast),
    .is_empty   (is_empty)
  );

  assign out_tdata = {{(OUT_DATA_W - VALUE_W - POS_W){1'b0}}, position, value_res};
  assign out_tuser = is_empty;

endmodule

/* verif/ssu_union_checker.sv */
// Checker for the sorted set union merge: keeps its own copy of both lists,
// predicts each merge's union from the accepted in_ beats, compares out_ beats.
// Depends on ssu_pkg only; sits beside the block and drives nothing on it.
`timescale 1ns / 1ps

module ssu_union_checker #(
  parameter int LIST_DEPTH = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [ssu_pkg::IN_DATA_W-1:0]  in_tdata,   // [31:0] value
  input  logic [ssu_pkg::FUNC_W-1:0]     in_tuser,   // [1:0] func
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [ssu_pkg::OUT_DATA_W-1:0] out_tdata,  // [31:0] value_res, [37:32] position
  input  logic [0:0]                     out_tuser,  // [0] is_empty
  input  logic                           out_tlast,
  output int unsigned                    errors,
  output int unsigned                    pending
);
  import ssu_pkg::*;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          pos;
    logic                      last;
    logic                      empty;
  } union_elem_t;

  logic signed [VALUE_W-1:0] set_a [LIST_DEPTH];
  logic signed [VALUE_W-1:0] set_b [LIST_DEPTH];
  int unsigned               fill_a = 0;
  int unsigned               fill_b = 0;
  union_elem_t               union_q [$];
  union_elem_t               want;
  union_elem_t               got;
  int unsigned               mismatches = 0;

  // one ascending walk over both lists, equal heads collapse into one element
  task automatic merge_sets();
    int unsigned               i;
    int unsigned               j;
    int unsigned               k;
    logic signed [VALUE_W-1:0] v;
    union_elem_t               e;
    i = 0;
    j = 0;
    k = 0;
    if (fill_a == 0 && fill_b == 0) begin
      e.value = '0;
      e.pos   = '0;
      e.last  = 1'b1;
      e.empty = 1'b1;
      union_q.push_back(e);
    end else begin
      while (i < fill_a || j < fill_b) begin
        if (i < fill_a && j < fill_b) begin
          if (set_a[i] < set_b[j]) begin
            v = set_a[i];
            i++;
          end else if (set_b[j] < set_a[i]) begin
            v = set_b[j];
            j++;
          end else begin
            v = set_a[i];
            i++;
            j++;
          end
        end else if (i < fill_a) begin
          v = set_a[i];
          i++;
        end else begin
          v = set_b[j];
          j++;
        end
        e.value = v;
        e.pos   = k[POS_W-1:0];
        e.last  = (i >= fill_a) && (j >= fill_b);
        e.empty = 1'b0;
        union_q.push_back(e);
        k++;
      end
    end
    fill_a = 0;
    fill_b = 0;
  endtask

  task automatic report(input string field, input longint exp_val, input longint act_val);
    $display("%0t: mismatch in %s, expected %0d, got %0d", $time, field, exp_val, act_val);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      fill_a = 0;
      fill_b = 0;
      union_q.delete();
    end else begin
      // result side first: a merge taken at this edge cannot have output yet
      if (out_tvalid && out_tready) begin
        got.value = out_tdata[VALUE_W-1:0];
        got.pos   = out_tdata[VALUE_W +: POS_W];
        got.last  = out_tlast;
        got.empty = out_tuser[0];
        if (union_q.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, got value %0d pos %0d",
                   $time, got.value, got.pos);
          mismatches++;
        end else begin
          want = union_q.pop_front();
          if (got.value !== want.value) report("value_res", want.value, got.value);
          if (got.pos !== want.pos)     report("position", want.pos, got.pos);
          if (got.last !== want.last)   report("last", want.last, got.last);
          if (got.empty !== want.empty) report("is_empty", want.empty, got.empty);
        end
      end
      if (in_tvalid && in_tready) begin
        case (in_tuser)
          FUNC_LOAD_A: begin
            if (fill_a < LIST_DEPTH) begin
              set_a[fill_a] = in_tdata[VALUE_W-1:0];
              fill_a++;
            end
          end
          FUNC_LOAD_B: begin
            if (fill_b < LIST_DEPTH) begin
              set_b[fill_b] = in_tdata[VALUE_W-1:0];
              fill_b++;
            end
          end
          FUNC_MERGE: merge_sets();
          default: ;
        endcase
      end
    end
    errors  <= mismatches;
    pending <= union_q.size();
  end

endmodule

/* verif/sorted_set_union_merge_test.sv */
// Top of the sorted set union merge testbench: clock, reset, load and merge
// stimulus, random back-pressure and the verdict. Depends on ssu_pkg, the
// block and ssu_union_checker, which does all prediction and comparison.
`timescale 1ns / 1ps

module sorted_set_union_merge_test;
  import ssu_pkg::*;

  localparam int DEPTH        = 32;
  localparam int RANDOM_ITEMS = 500;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 2 * DEPTH + 16;
  localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [FUNC_W-1:0]     in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [0:0]            out_tuser;
  logic                  out_tlast;

  int unsigned errors;
  int unsigned pending;
  int unsigned send_idle   = 28;
  int unsigned recv_idle   = 45;
  int unsigned sent_items  = 0;
  int unsigned idle_cycles = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  sorted_set_union_merge #(.LIST_DEPTH(DEPTH)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  ssu_union_checker #(.LIST_DEPTH(DEPTH)) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .errors    (errors),
    .pending   (pending)
  );

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  // watchdog: cycles in a row with no beat on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // valid stays high from one beat into the next unless a gap is drawn
  task automatic send_beat(input logic [FUNC_W-1:0] func, input logic [VALUE_W-1:0] value);
    while ($urandom_range(0, 99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= value;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (func != FUNC_SPARE) sent_items++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // mostly two sorted lists drawn from one ascending pool, so heads often tie;
  // the rest is random funcs and values, unsorted and with the spare code
  task automatic run_sets(input bit noisy);
    logic [VALUE_W-1:0] qa [$];
    logic [VALUE_W-1:0] qb [$];
    longint             v;
    int unsigned        pool;
    int unsigned        span;
    int unsigned        pick;
    if (noisy) begin
      repeat ($urandom_range(0, 12)) send_beat(FUNC_W'($urandom_range(0, 3)), $urandom());
    end else begin
      pool = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 10);
      case ($urandom_range(0, 2))
        0:       span = 3;
        1:       span = 1000;
        default: span = 32'h7fff_ffff;
      endcase
      case ($urandom_range(0, 3))
        0:       v = -64'sd2147483648;
        1:       v = -64'sd20;
        default: v = longint'($signed($urandom()));
      endcase
      repeat (pool) begin
        pick = $urandom_range(0, 9);
        if (pick <= 2 || (pick >= 6 && pick <= 8)) qa.push_back(v[VALUE_W-1:0]);
        if (pick >= 3 && pick <= 8) qb.push_back(v[VALUE_W-1:0]);
        if ($urandom_range(0, 11) == 0) qa.push_back(v[VALUE_W-1:0]);
        v += $urandom_range(0, span);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
      end
      while (qa.size() + qb.size() > 0) begin
        if (qb.size() == 0 || (qa.size() != 0 && $urandom_range(0, 1) == 1)) begin
          send_beat(FUNC_LOAD_A, qa.pop_front());
        end else begin
          send_beat(FUNC_LOAD_B, qb.pop_front());
        end
      end
    end
    send_beat(FUNC_MERGE, $urandom());
  endtask

  initial begin
    int unsigned target;
    int unsigned batch;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty union, then the unused code with nothing loaded
    send_beat(FUNC_MERGE, 32'h0);
    send_beat(FUNC_SPARE, 32'h1234_5678);
    // extremes on both sides, tied heads, a duplicate inside B
    send_beat(FUNC_LOAD_A, 32'h8000_0000);
    send_beat(FUNC_LOAD_B, 32'h8000_0000);
    send_beat(FUNC_LOAD_A, 32'hffff_ffff);
    send_beat(FUNC_LOAD_B, 32'h0000_0000);
    send_beat(FUNC_LOAD_A, 32'h0000_0000);
    send_beat(FUNC_LOAD_B, 32'h0000_0000);
    send_beat(FUNC_SPARE, 32'hdead_beef);
    send_beat(FUNC_LOAD_A, 32'h0000_0007);
    send_beat(FUNC_LOAD_B, 32'h0000_0005);
    send_beat(FUNC_LOAD_A, 32'h7fff_ffff);
    send_beat(FUNC_LOAD_B, 32'h7fff_ffff);
    send_beat(FUNC_MERGE, 32'hffff_ffff);
    // only list A, then only list B
    send_beat(FUNC_LOAD_A, 32'h0000_0003);
    send_beat(FUNC_LOAD_A, 32'h0000_0003);
    send_beat(FUNC_MERGE, 32'h0);
    send_beat(FUNC_LOAD_B, 32'hffff_fff7);
    send_beat(FUNC_MERGE, 32'h0);
    // unsorted input is walked as loaded
    send_beat(FUNC_LOAD_A, 32'h0000_000a);
    send_beat(FUNC_LOAD_A, 32'hffff_fff6);
    send_beat(FUNC_LOAD_B, 32'h0000_0000);
    send_beat(FUNC_MERGE, 32'h0);
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        send_idle <= 45;
        recv_idle <= 28;
      end else if (phase == 2) begin
        send_idle <= 0;
        recv_idle <= 0;
      end
      target = sent_items + RANDOM_ITEMS / 3;
      batch  = 0;
      while (sent_items < target) begin
        run_sets($urandom_range(0, 5) == 0);
        batch++;
        if (batch % 8 == 0) wait_drained();
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* sim.f */
design/ssu_pkg.sv
design/ssu_ram.sv
design/ssu_ctrl.sv
design/ssu_dpath.sv
design/sorted_set_union_merge.sv
verif/ssu_union_checker.sv
verif/sorted_set_union_merge_test.sv
